/* rtl/ucb_pkg.sv */
`timescale 1ns / 1ps

package ucb_pkg;

	// Default ring depths (one slot is kept empty, so a ring holds depth-1 bytes)
	localparam int RX_DEPTH_DEF = 128;
	localparam int TX_DEPTH_DEF = 64;

	// Entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Function codes on the func port
	localparam logic [1:0] FUNC_LINE_RX  = 2'd0;
	localparam logic [1:0] FUNC_HOST_WR  = 2'd1;
	localparam logic [1:0] FUNC_HOST_RD  = 2'd2;
	localparam logic [1:0] FUNC_TX_READY = 2'd3;

	// Decoded operation carried to the back end
	typedef enum logic [1:0] {
		OP_LINE_RX,
		OP_HOST_WR,
		OP_HOST_RD,
		OP_TX_READY
	} op_t;

	// One classified command
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       tx_ready;
	} cmd_t;

	// Back end sequencer states
	typedef enum logic {
		ST_EXEC,
		ST_RD_WAIT
	} state_t;

endpackage

/* rtl/ucb_ram.sv */
`timescale 1ns / 1ps

module ucb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/ucb_front.sv */
`timescale 1ns / 1ps

module ucb_front import ucb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// transaction input
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] data,
	input  logic       tx_ready,
	// classified commands toward the back end
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_DEPTH - 1);
	localparam logic [QCW-1:0] Q_FULL = QCW'(QUEUE_DEPTH);

	cmd_t           queue_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	cmd_t           cls;
	logic           push;
	logic           pop;

	// Classify: decode the function and drop fields the operation ignores
	always_comb begin
		cls.data     = 8'd0;
		cls.tx_ready = 1'b0;
		case (func)
			FUNC_LINE_RX: begin
				cls.op   = OP_LINE_RX;
				cls.data = data;
			end
			FUNC_HOST_WR: begin
				cls.op       = OP_HOST_WR;
				cls.data     = data;
				cls.tx_ready = tx_ready;
			end
			FUNC_HOST_RD: begin
				cls.op = OP_HOST_RD;
			end
			default: begin
				cls.op = OP_TX_READY;
			end
		endcase
	end

	assign in_ready  = (count_q != Q_FULL);
	assign cmd_valid = (count_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Queue entries
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Fill count stays within the queue
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= Q_FULL)
		else $error("command queue over-filled");

	// A push into an empty queue shows up at the back end next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && count_q == '0) |=> cmd_valid)
		else $error("pushed command not visible");

	// Pointers agree with the count when the queue is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step");

endmodule

/* rtl/ucb_back.sv */
`timescale 1ns / 1ps

module ucb_back import ucb_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// classified commands from the front end
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	// result transaction
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic       rx_dropped,
	output logic       write_refused,
	output logic       tx_irq_enable,
	output logic       rx_pending
);

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

	state_t           state_q, state_d;
	logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
	logic [TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
	logic [RX_AW-1:0] rx_head_nx, rx_tail_nx;
	logic [TX_AW-1:0] tx_head_nx, tx_tail_nx;
	logic             tx_irq_q, tx_irq_d;
	logic             rd_rx_q;
	logic             out_valid_q;
	logic             tx_valid_q, read_valid_q, rx_dropped_q, write_refused_q, rx_pending_q;
	logic [7:0]       tx_byte_q, read_data_q;

	logic             exec;
	logic             rx_empty, rx_full, tx_empty, tx_full;
	logic             rx_we, rx_re, tx_we, tx_re;
	logic             res_txv, res_drop, res_refused;
	logic [7:0]       res_txb;
	logic [7:0]       rx_rdata, tx_rdata;

	// Ring stores
	ucb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_head_q),
		.wdata (cmd.data),
		.re    (rx_re),
		.raddr (rx_tail_q),
		.rdata (rx_rdata)
	);

	ucb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_head_q),
		.wdata (cmd.data),
		.re    (tx_re),
		.raddr (tx_tail_q),
		.rdata (tx_rdata)
	);

	// Ring pointer wrap and occupancy
	assign rx_head_nx = (rx_head_q == RX_LAST) ? '0 : rx_head_q + 1'b1;
	assign rx_tail_nx = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + 1'b1;
	assign tx_head_nx = (tx_head_q == TX_LAST) ? '0 : tx_head_q + 1'b1;
	assign tx_tail_nx = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + 1'b1;
	assign rx_empty   = (rx_head_q == rx_tail_q);
	assign rx_full    = (rx_head_nx == rx_tail_q);
	assign tx_empty   = (tx_head_q == tx_tail_q);
	assign tx_full    = (tx_head_nx == tx_tail_q);

	// A command executes only when the result register can take it
	assign cmd_ready = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign exec      = cmd_valid && cmd_ready;

	// Next state, ring updates and result fields
	always_comb begin
		state_d     = state_q;
		rx_head_d   = rx_head_q;
		rx_tail_d   = rx_tail_q;
		tx_head_d   = tx_head_q;
		tx_tail_d   = tx_tail_q;
		tx_irq_d    = tx_irq_q;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		tx_we       = 1'b0;
		tx_re       = 1'b0;
		res_txv     = 1'b0;
		res_txb     = 8'd0;
		res_drop    = 1'b0;
		res_refused = 1'b0;
		case (state_q)
			ST_EXEC: begin
				if (exec) begin
					case (cmd.op)
						OP_LINE_RX: begin
							if (!rx_full) begin
								rx_we     = 1'b1;
								rx_head_d = rx_head_nx;
							end else begin
								res_drop = 1'b1;
							end
						end
						OP_HOST_WR: begin
							if (tx_empty && cmd.tx_ready) begin
								// direct send, interrupt enable untouched
								res_txv = 1'b1;
								res_txb = cmd.data;
							end else begin
								if (!tx_full) begin
									tx_we     = 1'b1;
									tx_head_d = tx_head_nx;
								end else begin
									res_refused = 1'b1;
								end
								tx_irq_d = 1'b1;
							end
						end
						OP_HOST_RD: begin
							if (!rx_empty) begin
								rx_re     = 1'b1;
								rx_tail_d = rx_tail_nx;
								state_d   = ST_RD_WAIT;
							end
						end
						default: begin
							if (!tx_empty) begin
								tx_re     = 1'b1;
								tx_tail_d = tx_tail_nx;
								res_txv   = 1'b1;
								state_d   = ST_RD_WAIT;
							end else begin
								tx_irq_d = 1'b0;
							end
						end
					endcase
				end
			end
			default: begin
				state_d = ST_EXEC;
			end
		endcase
	end

	// State, pointers and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_EXEC;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			tx_irq_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			tx_irq_q  <= tx_irq_d;
			if (state_q == ST_RD_WAIT) begin
				out_valid_q <= 1'b1;
			end else if (exec) begin
				out_valid_q <= (state_d == ST_EXEC);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register; a pop fills its byte from the RAM in the wait state that follows
	always_ff @(posedge clk) begin
		if (exec) begin
			rd_rx_q         <= rx_re;
			tx_valid_q      <= res_txv;
			tx_byte_q       <= res_txb;
			read_valid_q    <= rx_re;
			read_data_q     <= 8'd0;
			rx_dropped_q    <= res_drop;
			write_refused_q <= res_refused;
			rx_pending_q    <= (rx_head_d != rx_tail_d);
		end else if (state_q == ST_RD_WAIT) begin
			if (rd_rx_q) begin
				read_data_q <= rx_rdata;
			end else begin
				tx_byte_q <= tx_rdata;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = tx_valid_q;
	assign tx_byte       = tx_byte_q;
	assign read_valid    = read_valid_q;
	assign read_data     = read_data_q;
	assign rx_dropped    = rx_dropped_q;
	assign write_refused = write_refused_q;
	assign tx_irq_enable = tx_irq_q;
	assign rx_pending    = rx_pending_q;

	// The result register is free while a pop waits on RAM data
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_WAIT) |-> !out_valid_q)
		else $error("result register busy during ring read");

	// A ring read always leads to the wait state and then a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(rx_re || tx_re) |=> (state_q == ST_RD_WAIT) ##1 out_valid_q)
		else $error("ring read without result");

	// A refused write leaves the transmit interrupt enabled
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && write_refused_q) |-> tx_irq_q)
		else $error("refused write with interrupt disabled");

	// Only one ring access per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones({rx_we, rx_re, tx_we, tx_re}) <= 1)
		else $error("more than one ring access in a cycle");

endmodule

/* rtl/uart_buffered_channel_core.sv */
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// in        in_valid / in_ready   func, data, tx_ready
// out       out_valid / out_ready tx_valid, tx_byte, read_valid, read_data,
//                                 rx_dropped, write_refused, tx_irq_enable, rx_pending
//
// Each transaction passes a two-entry command queue and then the back end.
// Stores, direct sends and empty-ring cases end in the execute state; a pop also
// passes the read-wait state, for either ring, due to the registered RAM read port.
// Reset clears the ring pointers, the interrupt enable and the queue; RAMs are not cleared.
// A stalled output holds the back end; the queue keeps taking input until it is full.

module uart_buffered_channel_core import ucb_pkg::*; #(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] func,
	input  logic [7:0] data,
	input  logic       tx_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       read_valid,
	output logic [7:0] read_data,
	output logic       rx_dropped,
	output logic       write_refused,
	output logic       tx_irq_enable,
	output logic       rx_pending
);

	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	// Front end: accept and classify
	ucb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.data      (data),
		.tx_ready  (tx_ready),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Back end: ring buffers and results
	ucb_back #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.read_valid    (read_valid),
		.read_data     (read_data),
		.rx_dropped    (rx_dropped),
		.write_refused (write_refused),
		.tx_irq_enable (tx_irq_enable),
		.rx_pending    (rx_pending)
	);

endmodule
